>>> hw/rtl/kmer_best_match_distance_unit_assert.svh
// Assertion macros used by the RTL.
`ifndef KMER_BEST_MATCH_DISTANCE_UNIT_ASSERT_SVH
`define KMER_BEST_MATCH_DISTANCE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define KBMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define KBMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/kbmd_pkg.sv
`timescale 1ns / 1ps

package kbmd_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int MAX_SEQ_LEN = 1024;

  localparam int PATTERN_W = 2 * MAX_PATTERN;
  localparam int CNT_W     = $clog2(MAX_SEQ_LEN + 1);
  localparam int START_W   = $clog2(MAX_SEQ_LEN);
  localparam int LEN_W     = 6;
  localparam int POS_W     = 10;
  localparam int TOTAL_W   = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BASES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

  typedef struct packed {
    logic [POS_W-1:0]   best_position;
    logic [LEN_W-1:0]   hamming_distance;
    logic [TOTAL_W-1:0] total_distance;
    logic               window_found;
    logic               last_of_set;
  } result_t;

endpackage

>>> hw/rtl/kmer_best_match_distance_unit.sv
`timescale 1ns / 1ps

// Streams 2-bit bases and scores every full window among the first
// MAX_SEQ_LEN bases of a sequence against the configured k-mer. One base is
// taken per cycle, back to back: the window shift, the per-lane compare, the
// popcount and the best-match update all sit in one register-to-register
// stage. The result of a sequence is registered into a two-entry output queue
// as the base that ends it is taken, so input stalls only while both entries
// hold results not yet taken. Configuration writes are always ready and take
// effect on the next base; no clearing pass is needed after reset.
`include "kmer_best_match_distance_unit_assert.svh"

module kmer_best_match_distance_unit
  import kbmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           base,
  input  logic                 end_of_sequence,
  input  logic                 end_of_set,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_W-1:0]     best_position,
  output logic [LEN_W-1:0]     hamming_distance,
  output logic [TOTAL_W-1:0]   total_distance,
  output logic                 window_found,
  output logic                 last_of_set
);

  logic [63:0]          pattern_bases;
  logic [LEN_W-1:0]     pattern_length;

  logic [PATTERN_W-1:0] window_bases, window_bases_next;
  logic [CNT_W-1:0]     position_count, position_count_next;
  logic [LEN_W-1:0]     best_matches, best_matches_next;
  logic [START_W-1:0]   best_start, best_start_next;
  logic [TOTAL_W-1:0]   distance_sum, distance_sum_next;

  result_t              q0, q1, res;
  logic [1:0]           count;

  logic                 in_fire, out_fire, push;
  logic [LEN_W-1:0]     len;
  logic [PATTERN_W-1:0] rev, aligned;
  logic [6:0]           shamt;
  logic                 score_en, full;
  logic [PATTERN_W-1:0] win_new;
  logic [CNT_W-1:0]     cnt_new;
  logic [MAX_PATTERN-1:0] hit;
  logic [LEN_W-1:0]     match_cnt, bm_new, ham_dist;
  logic [START_W-1:0]   bs_new;
  logic [31:0]          pos_wide;
  logic [TOTAL_W:0]     sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign push      = in_fire && end_of_sequence;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bases  <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_BASES:  pattern_bases  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = pattern_length;
    end
  end

  // Pattern reversed, then shifted so base len-1 lines up with the newest lane.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      rev[2*k +: 2] = pattern_bases[2*(MAX_PATTERN-1-k) +: 2];
    end
    shamt   = 7'(2 * (MAX_PATTERN - int'(len)));
    aligned = rev >> shamt;
  end

  always_comb begin
    score_en = (position_count < CNT_W'(MAX_SEQ_LEN));
    win_new  = score_en ? ((window_bases << 2) | PATTERN_W'(base)) : window_bases;
    cnt_new  = score_en ? position_count + CNT_W'(1) : position_count;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      hit[j] = (j < int'(len)) && (win_new[2*j +: 2] == aligned[2*j +: 2]);
    end
    match_cnt = LEN_W'($countones(hit));
    full      = (cnt_new >= CNT_W'(len));

    bm_new = best_matches;
    bs_new = best_start;
    if (score_en && full && (match_cnt > best_matches)) begin
      bm_new = match_cnt;
      bs_new = START_W'(cnt_new - CNT_W'(len));
    end

    if (full) begin
      pos_wide = 32'(bs_new);
      ham_dist = (bm_new <= len) ? len - bm_new : '0;
    end else begin
      pos_wide = '0;
      ham_dist = len;
    end
    sum = (TOTAL_W+1)'(distance_sum) + (TOTAL_W+1)'(ham_dist);

    res.best_position    = pos_wide[POS_W-1:0];
    res.hamming_distance = ham_dist;
    res.total_distance   = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    res.window_found     = full;
    res.last_of_set      = end_of_set;

    window_bases_next   = win_new;
    position_count_next = cnt_new;
    best_matches_next   = bm_new;
    best_start_next     = bs_new;
    distance_sum_next   = distance_sum;
    if (end_of_sequence) begin
      window_bases_next   = '0;
      position_count_next = '0;
      best_matches_next   = '0;
      best_start_next     = '0;
      distance_sum_next   = end_of_set ? '0 : res.total_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bases   <= '0;
      position_count <= '0;
      best_matches   <= '0;
      best_start     <= '0;
      distance_sum   <= '0;
    end else if (in_fire) begin
      window_bases   <= window_bases_next;
      position_count <= position_count_next;
      best_matches   <= best_matches_next;
      best_start     <= best_start_next;
      distance_sum   <= distance_sum_next;
    end
  end

  // Two-entry result queue, head in q0.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(push) - 2'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((count - 2'(out_fire)) == 2'd0)) begin
      q0 <= res;
    end else if (out_fire) begin
      q0 <= q1;
    end
    if (push && ((count - 2'(out_fire)) != 2'd0)) begin
      q1 <= res;
    end
  end

  assign best_position    = q0.best_position;
  assign hamming_distance = q0.hamming_distance;
  assign total_distance   = q0.total_distance;
  assign window_found     = q0.window_found;
  assign last_of_set      = q0.last_of_set;

  `KBMD_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, count != 2'd3, "result queue overflow")
  `KBMD_ASSERT_NEXT(a_seq_clear, clk, rst, in_fire && end_of_sequence, position_count == '0 && best_matches == '0, "sequence state not cleared")
  `KBMD_ASSERT_NEXT(a_set_clear, clk, rst, in_fire && end_of_sequence && end_of_set, distance_sum == '0, "set total not cleared")
  `KBMD_ASSERT_NEXT(a_push_count, clk, rst, push && !out_fire, count == $past(count) + 2'd1, "result beat lost")
  `KBMD_ASSERT_NOW(a_dist_range, clk, rst, out_valid, hamming_distance <= LEN_W'(MAX_PATTERN), "distance out of range")

endmodule

>>> sim/tb_kmer_best_match_distance_unit.sv
`timescale 1ns / 1ps

module tb_kmer_best_match_distance_unit;
  import kbmd_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_SEQ_LEN  = MAX_SEQ_LEN + 76;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           base = '0;
  logic                 end_of_sequence = 1'b0;
  logic                 end_of_set = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [POS_W-1:0]     best_position;
  logic [LEN_W-1:0]     hamming_distance;
  logic [TOTAL_W-1:0]   total_distance;
  logic                 window_found;
  logic                 last_of_set;

  // mirror of the scoring state
  logic [63:0]      pat_bases = '0;
  logic [LEN_W-1:0] pat_len_reg = 6'd1;
  logic [63:0]      win_bases = '0;
  int unsigned      seq_pos = 0;
  int unsigned      best_hits = 0;
  int unsigned      best_at = 0;
  int unsigned      set_total = 0;

  result_t    scores_due[$];
  logic [1:0] seq_buf[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  kmer_best_match_distance_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .base             (base),
    .end_of_sequence  (end_of_sequence),
    .end_of_set       (end_of_set),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .best_position    (best_position),
    .hamming_distance (hamming_distance),
    .total_distance   (total_distance),
    .window_found     (window_found),
    .last_of_set      (last_of_set)
  );

  function automatic int unsigned kmer_len();
    int unsigned l;
    l = pat_len_reg;
    if (l < 1) l = 1;
    if (l > MAX_PATTERN) l = MAX_PATTERN;
    return l;
  endfunction

  function automatic void score_base(logic [1:0] b, logic eos, logic eset);
    int unsigned len;
    int unsigned hits;
    int unsigned distance;
    int unsigned pos;
    int unsigned total;
    logic        found;
    result_t     r;
    len = kmer_len();
    if (seq_pos < MAX_SEQ_LEN) begin
      win_bases = {win_bases[61:0], b};
      seq_pos++;
      if (seq_pos >= len) begin
        hits = 0;
        for (int i = 0; i < len; i++)
          if (win_bases[2*(len-1-i) +: 2] == pat_bases[2*i +: 2]) hits++;
        if (hits > best_hits) begin
          best_hits = hits;
          best_at = seq_pos - len;
        end
      end
    end
    if (!eos) return;
    found = (seq_pos >= len);
    if (found) begin
      pos = best_at;
      distance = (best_hits <= len) ? len - best_hits : 0;
    end else begin
      pos = 0;
      distance = len;
    end
    total = set_total + distance;
    if (total > TOTAL_MAX) total = TOTAL_MAX;
    r.best_position = pos[POS_W-1:0];
    r.hamming_distance = distance[LEN_W-1:0];
    r.total_distance = total[TOTAL_W-1:0];
    r.window_found = found;
    r.last_of_set = eset;
    scores_due.push_back(r);
    set_total = eset ? 0 : total;
    win_bases = '0;
    seq_pos = 0;
    best_hits = 0;
    best_at = 0;
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    result_t r;
    if (!rst && out_valid && out_ready) begin
      if (scores_due.size() == 0) begin
        $error("unexpected result beat: best_position %0d hamming_distance %0d",
               best_position, hamming_distance);
        mismatch_count++;
      end else begin
        r = scores_due.pop_front();
        if (best_position !== r.best_position) begin
          $error("best_position expected %0d actual %0d", r.best_position, best_position);
          mismatch_count++;
        end
        if (hamming_distance !== r.hamming_distance) begin
          $error("hamming_distance expected %0d actual %0d",
                 r.hamming_distance, hamming_distance);
          mismatch_count++;
        end
        if (total_distance !== r.total_distance) begin
          $error("total_distance expected %0d actual %0d", r.total_distance, total_distance);
          mismatch_count++;
        end
        if (window_found !== r.window_found) begin
          $error("window_found expected %0b actual %0b", r.window_found, window_found);
          mismatch_count++;
        end
        if (last_of_set !== r.last_of_set) begin
          $error("last_of_set expected %0b actual %0b", r.last_of_set, last_of_set);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_base(input logic [1:0] b, input logic eos, input logic eset);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    base <= b;
    end_of_sequence <= eos;
    end_of_set <= eset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    score_base(b, eos, eset);
  endtask

  // sends seq_buf as one sequence; noisy sets stray end_of_set flags
  task automatic push_seq(input logic eset, input logic noisy);
    logic last;
    for (int i = 0; i < seq_buf.size(); i++) begin
      last = (i == seq_buf.size() - 1);
      push_base(seq_buf[i], last, last ? eset : (noisy & 1'($urandom_range(1))));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scores_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PATTERN_BASES) pat_bases = data;
    else if (idx == REG_PATTERN_LENGTH) pat_len_reg = data[LEN_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_seq(input int n, input logic [1:0] b);
    seq_buf.delete();
    repeat (n) seq_buf.push_back(b);
  endtask

  task automatic test_reset_values();
    fill_seq(1, BASE_A);
    push_seq(1'b0, 1'b0);
    seq_buf = '{BASE_T, BASE_G, BASE_A, BASE_C};
    push_seq(1'b1, 1'b0);
    fill_seq(2, BASE_T);
    push_seq(1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_PATTERN_BASES, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd32);
    fill_seq(MAX_PATTERN, BASE_T);
    push_seq(1'b0, 1'b0);
    seq_buf.push_front(BASE_A);
    push_seq(1'b1, 1'b0);
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    seq_buf = '{BASE_G, BASE_T};
    push_seq(1'b0, 1'b0);
    write_reg(REG_PATTERN_LENGTH, 64'd63);
    fill_seq(MAX_PATTERN - 1, BASE_T);
    push_seq(1'b1, 1'b0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    write_reg(REG_PATTERN_BASES, '0);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    seq_buf = '{BASE_C, BASE_A};
    push_seq(1'b0, 1'b0);
  endtask

  task automatic test_short_sequence();
    write_reg(REG_PATTERN_BASES, {$urandom, $urandom});
    write_reg(REG_PATTERN_LENGTH, 64'd5);
    seq_buf = '{BASE_C, BASE_G, BASE_T};
    push_seq(1'b1, 1'b0);
  endtask

  task automatic test_length_change_mid_sequence();
    write_reg(REG_PATTERN_BASES, '0);
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    repeat (10) push_base(BASE_A, 1'b0, 1'b0);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    push_base(BASE_A, 1'b1, 1'b0);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    repeat (3) push_base(BASE_T, 1'b0, 1'b0);
    write_reg(REG_PATTERN_LENGTH, 64'd6);
    repeat (2) push_base(BASE_A, 1'b0, 1'b0);
    push_base(BASE_C, 1'b1, 1'b1);
  endtask

  task automatic test_stray_set_end();
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    push_base(BASE_A, 1'b0, 1'b1);
    push_base(BASE_G, 1'b0, 1'b1);
    push_base(BASE_A, 1'b1, 1'b0);
    push_base(BASE_T, 1'b0, 1'b1);
    push_base(BASE_A, 1'b1, 1'b1);
  endtask

  // best window sits at the last scored position; bases past it are ignored
  task automatic test_long_sequence();
    write_reg(REG_PATTERN_BASES, '0);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    seq_buf.delete();
    for (int i = 0; i < LONG_SEQ_LEN; i++)
      seq_buf.push_back((i >= MAX_SEQ_LEN - 1) ? BASE_A : BASE_T);
    push_seq(1'b1, 1'b0);
  endtask

  task automatic test_total_saturation();
    send_idle_pct = 16;
    recv_stall_pct = 16;
    write_reg(REG_PATTERN_LENGTH, 64'd32);
    repeat (132) begin
      fill_seq(1, 2'($urandom_range(3)));
      push_seq(1'b0, 1'b0);
    end
    fill_seq(3, BASE_G);
    push_seq(1'b1, 1'b0);
    fill_seq(1, BASE_C);
    push_seq(1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_bases, input logic [LEN_W-1:0] len_val);
    int          sent;
    int          n;
    int unsigned len;
    int unsigned off;
    logic        noisy;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(REG_PATTERN_BASES, {$urandom, $urandom});
    write_reg(REG_PATTERN_LENGTH, 64'(len_val));
    sent = 0;
    while (sent < n_bases) begin
      if ($urandom_range(15) == 0) write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(63)));
      len = kmer_len();
      n = ($urandom_range(9) == 0) ? $urandom_range(90, 41) : $urandom_range(40, 1);
      seq_buf.delete();
      repeat (n) seq_buf.push_back(2'($urandom_range(3)));
      if ($urandom_range(2) != 0 && n >= len) begin
        off = $urandom_range(n - len);
        for (int i = 0; i < len; i++) seq_buf[off + i] = pat_bases[2*i +: 2];
        if ($urandom_range(1) != 0) seq_buf[off + $urandom_range(len - 1)] = 2'($urandom_range(3));
      end
      noisy = ($urandom_range(9) == 0);
      push_seq($urandom_range(4) == 0, noisy);
      sent += n;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_register_extremes();
    test_short_sequence();
    test_length_change_mid_sequence();
    test_stray_set_end();
    test_long_sequence();
    test_total_saturation();
    test_random_traffic(0, 0, 150, 6'd32);
    test_random_traffic(75, 0, 150, 6'd1);
    test_random_traffic(0, 75, 150, 6'($urandom_range(63)));
    test_random_traffic(16, 16, 150, 6'd0);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/kbmd_pkg.sv
hw/rtl/kmer_best_match_distance_unit.sv
sim/tb_kmer_best_match_distance_unit.sv
